// ===== rtl/utbp_pkg.sv =====
`default_nettype none

package utbp_pkg;

    // Default sizes of the bucket arithmetic.
    localparam int FRACTION_BITS_DEF = 8;
    localparam int BURST_BITS_DEF    = 24;

    // Field widths of the channels.
    localparam int COUNT_W     = 16;
    localparam int SIZE_W      = 17;
    localparam int REFILL_W    = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Register reset values.
    localparam logic [REFILL_W-1:0] REFILL_RESET = 32'd256;
    localparam int MAX_BURST_RESET = 65536;

    // Ethernet and UDP framing overheads, in bytes.
    localparam logic [SIZE_W-1:0] IP_UDP_HDR      = 17'd28;
    localparam logic [SIZE_W-1:0] WIRE_OVERHEAD   = 17'd38;
    localparam logic [SIZE_W-1:0] MIN_ETH_PAYLOAD = 17'd46;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] REG_REFILL    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BURST = 8'd1;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SEND = 1'b1
    } opcode_t;

    typedef enum logic {
        ST_GRANTED = 1'b0,
        ST_BUSY    = 1'b1
    } status_t;

    // Wire bytes of a frame carrying a UDP payload of the given size.
    function automatic logic [SIZE_W-1:0] wire_bytes(input logic [COUNT_W-1:0] payload);
        logic [SIZE_W-1:0] ip;
        ip = SIZE_W'(payload) + IP_UDP_HDR;
        return WIRE_OVERHEAD + ((ip > MIN_ETH_PAYLOAD) ? ip : MIN_ETH_PAYLOAD);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/utbp_ifs.sv =====
`default_nettype none

// Channel carrying ticks and send requests into the pacer.
interface utbp_item_if;
    import utbp_pkg::*;

    logic                 valid;
    logic                 ready;
    opcode_t              opcode;
    logic [COUNT_W-1:0]   byte_count;
    logic                 as_udp_payload;

    modport source (output valid, opcode, byte_count, as_udp_payload, input ready);
    modport sink   (input valid, opcode, byte_count, as_udp_payload, output ready);
endinterface

// Channel carrying grants and busy rejections out of the pacer.
interface utbp_result_if;
    import utbp_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [SIZE_W-1:0]   granted_bytes;

    modport source (output valid, status, granted_bytes, input ready);
    modport sink   (input valid, status, granted_bytes, output ready);
endinterface

// Register write channel.
interface utbp_cfg_if;
    import utbp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_INDEX_W-1:0]  index;
    logic [CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/udp_wire_token_bucket_pacer.sv =====
// Token-bucket pacer for Ethernet/UDP sends.
// The item channel takes ticks (opcode OP_TICK) and send requests (OP_SEND).
// A tick adds refill_per_tick to the bucket, saturating at max_burst bytes.
// A send request loads a pending byte count, raw or converted from a UDP
// payload size to wire bytes. All items but busy sends try to take one
// chunk of at most max_burst bytes from the pending count; taking the last
// chunk produces a grant on the result channel. A send request that arrives
// while another is pending gets a busy result; the pending one is untouched.
// The cfg channel writes register 0 (refill_per_tick) or 1 (max_burst); a
// write to either empties the bucket. It is always ready and should be used
// only while no item is in flight.
// An accepted item waits in the input register; the update stage writes any
// result it produces into the result register. Throughput: one item per
// cycle while the result register is not stalled, set by the single update
// stage that reads and writes the bucket and pending state.
// Reset empties the bucket, drops any pending request and loads the register
// defaults. When the receiver stalls, one item waits in the input register
// and the item channel deasserts ready until the result register drains.
`default_nettype none

module udp_wire_token_bucket_pacer #(
    parameter int FRACTION_BITS = utbp_pkg::FRACTION_BITS_DEF,
    parameter int BURST_BITS    = utbp_pkg::BURST_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    utbp_item_if.sink            item,
    utbp_result_if.source        result,
    utbp_cfg_if.sink             cfg
);
    import utbp_pkg::*;

    localparam int LEVEL_W = BURST_BITS + FRACTION_BITS;
    localparam int SUM_W   = ((LEVEL_W > REFILL_W) ? LEVEL_W : REFILL_W) + 1;
    localparam int NEED_W  = SIZE_W + FRACTION_BITS;
    localparam int CMP_W   = (NEED_W > LEVEL_W) ? NEED_W : LEVEL_W;
    localparam int BC_W    = (BURST_BITS > SIZE_W) ? BURST_BITS : SIZE_W;

    // Configuration registers.
    logic [REFILL_W-1:0]   refill_reg, refill_next;
    logic [BURST_BITS-1:0] burst_reg, burst_next;

    // Bucket and pending request state.
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [SIZE_W-1:0]     pend_rem_reg, pend_rem_next;
    logic [SIZE_W-1:0]     pend_total_reg, pend_total_next;

    // Input register.
    logic                  in_vld_reg, in_vld_next;
    opcode_t               in_op_reg;
    logic [COUNT_W-1:0]    in_count_reg;
    logic                  in_udp_reg;

    // Result register.
    logic                  out_vld_reg, out_vld_next;
    status_t               out_status_reg, out_status_next;
    logic [SIZE_W-1:0]     out_bytes_reg, out_bytes_next;

    logic                  advance;
    logic                  in_take;
    logic                  cfg_take;
    logic [BURST_BITS-1:0] burst_eff;
    logic [LEVEL_W-1:0]    cap;
    logic [SUM_W-1:0]      lvl_sum;
    logic [LEVEL_W-1:0]    level_mid;
    logic [SIZE_W-1:0]     req_size;
    logic                  busy_hit;
    logic                  load_vld;
    logic [SIZE_W-1:0]     load_rem;
    logic [SIZE_W-1:0]     load_total;
    logic [SIZE_W-1:0]     chunk;
    logic [NEED_W-1:0]     need;
    logic                  chunk_ok;
    logic [LEVEL_W-1:0]    drain_level;
    logic [SIZE_W-1:0]     drain_rem;
    logic                  done;
    logic                  has_result;

    // The update stage runs whenever the input register holds an item and the result register can take its output.
    assign advance    = in_vld_reg && (!out_vld_reg || result.ready);
    assign item.ready = !in_vld_reg || advance;
    assign in_take    = item.valid && item.ready;
    assign cfg.ready  = 1'b1;
    assign cfg_take   = cfg.valid;

    assign result.valid         = out_vld_reg;
    assign result.status        = out_status_reg;
    assign result.granted_bytes = out_bytes_reg;

    // A burst of zero behaves as one byte.
    assign burst_eff = (burst_reg == '0) ? BURST_BITS'(1) : burst_reg;
    assign cap       = LEVEL_W'(burst_eff) << FRACTION_BITS;

    // Tick refill with saturation at the bucket capacity.
    always_comb
    begin
        lvl_sum = SUM_W'(level_reg) + SUM_W'(refill_reg);
        if (in_op_reg == OP_TICK)
        begin
            level_mid = (lvl_sum > SUM_W'(cap)) ? cap : LEVEL_W'(lvl_sum);
        end
        else
        begin
            level_mid = level_reg;
        end
    end

    // Request sizing and loading of the pending slot.
    always_comb
    begin
        req_size   = in_udp_reg ? wire_bytes(in_count_reg) : SIZE_W'(in_count_reg);
        busy_hit   = (in_op_reg == OP_SEND) && pend_vld_reg;
        load_vld   = pend_vld_reg;
        load_rem   = pend_rem_reg;
        load_total = pend_total_reg;
        if ((in_op_reg == OP_SEND) && !pend_vld_reg)
        begin
            load_vld   = 1'b1;
            load_rem   = req_size;
            load_total = req_size;
        end
    end

    // Take at most one chunk the bucket covers.
    always_comb
    begin
        chunk       = (BC_W'(load_rem) < BC_W'(burst_eff)) ? load_rem : SIZE_W'(burst_eff);
        need        = NEED_W'(chunk) << FRACTION_BITS;
        chunk_ok    = load_vld && (load_rem != '0) && (CMP_W'(level_mid) >= CMP_W'(need));
        drain_level = level_mid;
        drain_rem   = load_rem;
        if (chunk_ok)
        begin
            drain_level = LEVEL_W'(CMP_W'(level_mid) - CMP_W'(need));
            drain_rem   = load_rem - chunk;
        end
        done = load_vld && (drain_rem == '0);
    end

    // Next state of the pacer and the result register.
    always_comb
    begin
        refill_next     = refill_reg;
        burst_next      = burst_reg;
        level_next      = level_reg;
        pend_vld_next   = pend_vld_reg;
        pend_rem_next   = pend_rem_reg;
        pend_total_next = pend_total_reg;
        has_result      = 1'b0;
        out_status_next = out_status_reg;
        out_bytes_next  = out_bytes_reg;

        if (advance)
        begin
            if (busy_hit)
            begin
                has_result      = 1'b1;
                out_status_next = ST_BUSY;
                out_bytes_next  = req_size;
            end
            else
            begin
                level_next      = drain_level;
                pend_vld_next   = load_vld && !done;
                pend_rem_next   = drain_rem;
                pend_total_next = load_total;
                if (done)
                begin
                    has_result      = 1'b1;
                    out_status_next = ST_GRANTED;
                    out_bytes_next  = load_total;
                end
            end
        end

        // A write to register 0 or 1 empties the bucket.
        if (cfg_take)
        begin
            case (cfg.index)
                REG_REFILL:
                begin
                    refill_next = cfg.data;
                    level_next  = '0;
                end
                REG_MAX_BURST:
                begin
                    burst_next = BURST_BITS'(cfg.data);
                    level_next = '0;
                end
                default:
                begin
                    level_next = level_next;
                end
            endcase
        end

        if (advance)
        begin
            out_vld_next = has_result;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end

        in_vld_next = in_take || (in_vld_reg && !advance);
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refill_reg     <= REFILL_RESET;
            burst_reg      <= BURST_BITS'(MAX_BURST_RESET);
            level_reg      <= '0;
            pend_vld_reg   <= 1'b0;
            pend_rem_reg   <= '0;
            pend_total_reg <= '0;
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            refill_reg     <= refill_next;
            burst_reg      <= burst_next;
            level_reg      <= level_next;
            pend_vld_reg   <= pend_vld_next;
            pend_rem_reg   <= pend_rem_next;
            pend_total_reg <= pend_total_next;
            in_vld_reg     <= in_vld_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg    <= item.opcode;
            in_count_reg <= item.byte_count;
            in_udp_reg   <= item.as_udp_payload;
        end
        out_status_reg <= out_status_next;
        out_bytes_reg  <= out_bytes_next;
    end

endmodule

`default_nettype wire
